>>> rtl/core/assert_macros.svh
// Assertion helpers used by the scheduler top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RRTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("scheduler check failed");
`define RRTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("scheduler sequence check failed");
`else
`define RRTS_ASSERT(lbl, clk, rstn, prop)
`define RRTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/core/rrts_pkg.sv
package rrts_pkg;

  localparam int MaxTasks  = 16;
  localparam int IdBits    = 16;
  localparam int IdxBits   = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int IdCmpBits = (IdBits > 16) ? IdBits : 16;
  localparam int OutIdBits = 16;

  typedef logic [IdBits-1:0]    id_t;
  typedef logic [IdxBits-1:0]   idx_t;
  typedef logic [IdCmpBits-1:0] id_cmp_t;
  typedef logic [OutIdBits-1:0] out_id_t;

  localparam id_t  InvalidId = {IdBits{1'b1}};
  localparam idx_t LastSlot  = idx_t'(MaxTasks - 1);

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_SET    = 2'd1,
    ACT_SELECT = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_BLOCKED = 2'd3
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'b01,
    PH_APPLY = 2'b10
  } phase_e;

  // Commands broadcast from the sequencer to every cell.
  typedef struct packed {
    logic    scan_en;
    logic    apply_en;
    action_e op;
    state_e  new_state;
    out_id_t task_id;
    id_t     next_id;
    logic    create_go;
    logic    set_go;
    logic    any_hi;
  } ctrl_t;

  // Priority chain, lowest slot first.
  typedef struct packed {
    logic empty_seen;
    logic match_seen;
    logic hi_seen;
    logic rdy_seen;
    logic after_cur;
  } scan_t;

  // Winner id and index collected along the row.
  typedef struct packed {
    id_t  sel_id;
    idx_t sel_idx;
  } pick_t;

endpackage

>>> rtl/core/rrts_cell.sv
module rrts_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rrts_pkg::ctrl_t ctrl_i,
  input  logic            is_cur_i,
  input  rrts_pkg::idx_t  idx_i,
  input  rrts_pkg::scan_t scan_i,
  output rrts_pkg::scan_t scan_o,
  input  rrts_pkg::pick_t pick_i,
  output rrts_pkg::pick_t pick_o
);

  rrts_pkg::state_e state_q, state_d;
  rrts_pkg::id_t    id_q, id_d;
  logic             empty_win_q, match_win_q, hi_win_q, lo_win_q;
  logic             empty_win_d, match_win_d, hi_win_d, lo_win_d;
  logic             is_empty, is_cand, is_match, hi_cand, win;

  always_comb begin
    is_empty = (state_q == rrts_pkg::ST_EMPTY);
    // a running current slot is demoted first, so it counts as ready
    is_cand  = (state_q == rrts_pkg::ST_READY) ||
               (is_cur_i && (state_q == rrts_pkg::ST_RUNNING));
    is_match = !is_empty &&
               (rrts_pkg::id_cmp_t'(id_q) == rrts_pkg::id_cmp_t'(ctrl_i.task_id));
    hi_cand  = is_cand && scan_i.after_cur;

    scan_o.empty_seen = scan_i.empty_seen | is_empty;
    scan_o.match_seen = scan_i.match_seen | is_match;
    scan_o.hi_seen    = scan_i.hi_seen | hi_cand;
    scan_o.rdy_seen   = scan_i.rdy_seen | is_cand;
    scan_o.after_cur  = scan_i.after_cur | is_cur_i;

    empty_win_d = is_empty && !scan_i.empty_seen;
    match_win_d = is_match && !scan_i.match_seen;
    hi_win_d    = hi_cand && !scan_i.hi_seen;
    lo_win_d    = is_cand && !scan_i.rdy_seen;
  end

  assign win = (ctrl_i.op == rrts_pkg::ACT_SELECT) &&
               (ctrl_i.any_hi ? hi_win_q : lo_win_q);

  always_comb begin
    pick_o.sel_id  = pick_i.sel_id | (win ? id_q : '0);
    pick_o.sel_idx = pick_i.sel_idx | (win ? idx_i : '0);
  end

  always_comb begin
    state_d = state_q;
    id_d    = id_q;
    if (ctrl_i.apply_en) begin
      case (ctrl_i.op)
        rrts_pkg::ACT_CREATE: begin
          if (ctrl_i.create_go && empty_win_q) begin
            state_d = rrts_pkg::ST_READY;
            id_d    = ctrl_i.next_id;
          end
        end
        rrts_pkg::ACT_SET: begin
          if (ctrl_i.set_go && match_win_q) begin
            state_d = ctrl_i.new_state;
          end
        end
        rrts_pkg::ACT_SELECT: begin
          if (win) begin
            state_d = rrts_pkg::ST_RUNNING;
          end else if (is_cur_i && (state_q == rrts_pkg::ST_RUNNING)) begin
            state_d = rrts_pkg::ST_READY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrts_pkg::ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    if (ctrl_i.scan_en) begin
      empty_win_q <= empty_win_d;
      match_win_q <= match_win_d;
      hi_win_q    <= hi_win_d;
      lo_win_q    <= lo_win_d;
    end
  end

endmodule

>>> rtl/core/round_robin_task_scheduler_unit.sv
// Channel   Handshake               Payload
// command   start_i & !busy_o       action_i, task_id_i, new_state_i
// result    valid_o (one cycle)     ok_o, result_id_o
//
// Accepting a command latches the winners of the cell row's priority chains;
// the apply phase then applies the update and registers the result, shown
// with valid_o once the unit is idle again, when a new command may already
// be accepted. The ripple through the slot cells sets the path.
// Reset empties all slots and points the current slot at the last one.
// The result cannot be stalled; busy_o is high only in the apply cycle.
`include "assert_macros.svh"

module round_robin_task_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] task_id_i,
  input  logic [1:0]  new_state_i,
  output logic        busy_o,
  output logic        valid_o,
  output logic        ok_o,
  output logic [15:0] result_id_o
);

  rrts_pkg::phase_e  phase_q, phase_d;
  rrts_pkg::action_e op_q;
  rrts_pkg::state_e  req_q;
  rrts_pkg::idx_t    cur_q, cur_d;
  rrts_pkg::id_t     next_id_q, next_id_d;
  logic              any_empty_q, any_match_q, any_hi_q, any_rdy_q;
  logic              accept, apply, create_go, set_go, ok_d;
  rrts_pkg::out_id_t res_id_d;
  rrts_pkg::ctrl_t   ctrl;
  rrts_pkg::scan_t   scan_c [rrts_pkg::MaxTasks+1];
  rrts_pkg::pick_t   pick_c [rrts_pkg::MaxTasks+1];
  logic [rrts_pkg::MaxTasks-1:0] is_cur;

  assign busy_o    = (phase_q == rrts_pkg::PH_APPLY);
  assign accept    = start_i && !busy_o;
  assign apply     = busy_o;
  assign create_go = any_empty_q && (next_id_q != rrts_pkg::InvalidId);
  assign set_go    = (req_q inside {rrts_pkg::ST_READY, rrts_pkg::ST_BLOCKED}) && any_match_q;

  always_comb begin
    ctrl.scan_en   = accept;
    ctrl.apply_en  = apply;
    ctrl.op        = op_q;
    ctrl.new_state = req_q;
    ctrl.task_id   = task_id_i;
    ctrl.next_id   = next_id_q;
    ctrl.create_go = create_go;
    ctrl.set_go    = set_go;
    ctrl.any_hi    = any_hi_q;
  end

  assign scan_c[0] = '0;
  assign pick_c[0] = '0;

  for (genvar i = 0; i < rrts_pkg::MaxTasks; i++) begin : g_cell
    assign is_cur[i] = (cur_q == rrts_pkg::idx_t'(i));
    rrts_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .is_cur_i (is_cur[i]),
      .idx_i    (rrts_pkg::idx_t'(i)),
      .scan_i   (scan_c[i]),
      .scan_o   (scan_c[i+1]),
      .pick_i   (pick_c[i]),
      .pick_o   (pick_c[i+1])
    );
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      rrts_pkg::PH_IDLE: begin
        if (accept) begin
          phase_d = rrts_pkg::PH_APPLY;
        end
      end
      rrts_pkg::PH_APPLY: phase_d = rrts_pkg::PH_IDLE;
      default:            phase_d = rrts_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    ok_d      = 1'b0;
    res_id_d  = '0;
    next_id_d = next_id_q;
    cur_d     = cur_q;
    case (op_q)
      rrts_pkg::ACT_CREATE: begin
        ok_d = create_go;
        if (create_go) begin
          res_id_d = rrts_pkg::out_id_t'(next_id_q);
          if (apply) begin
            next_id_d = rrts_pkg::id_t'(next_id_q + 1'b1);
          end
        end
      end
      rrts_pkg::ACT_SET: ok_d = set_go;
      rrts_pkg::ACT_SELECT: begin
        ok_d = any_rdy_q;
        if (any_rdy_q) begin
          res_id_d = rrts_pkg::out_id_t'(pick_c[rrts_pkg::MaxTasks].sel_id);
          if (apply) begin
            cur_d = pick_c[rrts_pkg::MaxTasks].sel_idx;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rrts_pkg::PH_IDLE;
      cur_q     <= rrts_pkg::LastSlot;
      next_id_q <= '0;
      valid_o   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cur_q     <= cur_d;
      next_id_q <= next_id_d;
      valid_o   <= apply;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= rrts_pkg::action_e'(action_i);
      req_q       <= rrts_pkg::state_e'(new_state_i);
      any_empty_q <= scan_c[rrts_pkg::MaxTasks].empty_seen;
      any_match_q <= scan_c[rrts_pkg::MaxTasks].match_seen;
      any_hi_q    <= scan_c[rrts_pkg::MaxTasks].hi_seen;
      any_rdy_q   <= scan_c[rrts_pkg::MaxTasks].rdy_seen;
    end
    if (apply) begin
      ok_o        <= ok_d;
      result_id_o <= res_id_d;
    end
  end

  `RRTS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy_o)
  `RRTS_ASSERT_NEXT(a_apply_result, clk_i, rst_ni, busy_o, valid_o && !busy_o)
  `RRTS_ASSERT(a_fail_zero_id, clk_i, rst_ni, (valid_o && !ok_o) |-> (result_id_o == '0))
  `RRTS_ASSERT(a_one_current, clk_i, rst_ni, $onehot(is_cur))

endmodule

>>> dv/rrts_checker.sv
`timescale 1ns / 1ps

module rrts_checker
  import rrts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] task_id_i,
  input  logic [1:0]  new_state_i,
  input  logic        valid_i,
  input  logic        ok_i,
  input  logic [15:0] result_id_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic    ok;
    out_id_t rid;
  } reply_t;

  // Shadow copy of the task table.
  state_e    slot_state [MaxTasks];
  id_t       slot_id    [MaxTasks];
  logic [4:0] tasks_made;
  id_t       id_ctr;
  idx_t      cur_slot;

  reply_t replies_due[$];

  function automatic void clear_table();
    for (int s = 0; s < MaxTasks; s++) begin
      slot_state[s] = ST_EMPTY;
      slot_id[s]    = InvalidId;
    end
    tasks_made = '0;
    id_ctr     = '0;
    cur_slot   = LastSlot;
  endfunction

  // Applies one command to the shadow table and returns the scheduler's answer.
  function automatic reply_t scheduler_response(logic [1:0] act, logic [15:0] tid,
                                                logic [1:0] st);
    reply_t r;
    logic   done;
    id_t    got;
    int     c;
    done = 1'b0;
    got  = '0;
    case (act)
      ACT_CREATE: begin
        if (tasks_made < MaxTasks && id_ctr != InvalidId) begin
          for (int s = 0; s < MaxTasks; s++) begin
            if (slot_state[s] == ST_EMPTY) begin
              slot_id[s]    = id_ctr;
              slot_state[s] = ST_READY;
              got           = id_ctr;
              id_ctr        = id_ctr + 1'b1;
              tasks_made    = tasks_made + 1'b1;
              done          = 1'b1;
              break;
            end
          end
        end
      end
      ACT_SET: begin
        if (st == ST_READY || st == ST_BLOCKED) begin
          for (int s = 0; s < MaxTasks; s++) begin
            if (slot_id[s] == id_t'(tid) && slot_state[s] != ST_EMPTY) begin
              slot_state[s] = state_e'(st);
              done          = 1'b1;
              break;
            end
          end
        end
      end
      ACT_SELECT: begin
        if (tasks_made != 0) begin
          if (slot_state[cur_slot] == ST_RUNNING) slot_state[cur_slot] = ST_READY;
          for (int k = 1; k <= MaxTasks; k++) begin
            c = (int'(cur_slot) + k) % MaxTasks;
            if (slot_state[c] == ST_READY) begin
              slot_state[c] = ST_RUNNING;
              cur_slot      = idx_t'(c);
              got           = slot_id[c];
              done          = 1'b1;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.ok  = done;
    r.rid = (done && act != ACT_SET) ? out_id_t'(got) : '0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t due;
    if (!rst_ni) begin
      clear_table();
      replies_due.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      // Results are checked before the new transaction is predicted.
      if (valid_i) begin
        if (replies_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result with nothing outstanding: ok=%0b id=%0d",
                     $realtime, ok_i, result_id_i);
        end else begin
          due = replies_due.pop_front();
          if (ok_i !== due.ok || result_id_i !== due.rid) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch: expected ok=%0b id=%0d, got ok=%0b id=%0d",
                       $realtime, due.ok, due.rid, ok_i, result_id_i);
          end
        end
      end
      if (start_i && !busy_i)
        replies_due.push_back(scheduler_response(action_i, task_id_i, new_state_i));
      pending_o <= replies_due.size();
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rrts_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int RandomCmds = 1600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  action_i = '0;
  logic [15:0] task_id_i = '0;
  logic [1:0]  new_state_i = '0;
  logic        busy_o;
  logic        valid_o;
  logic        ok_o;
  logic [15:0] result_id_o;
  int          fail_count;
  int          pending;

  int burst_left = 0;
  bit no_gap = 1'b0;

  round_robin_task_scheduler_unit dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .action_i,
    .task_id_i,
    .new_state_i,
    .busy_o,
    .valid_o,
    .ok_o,
    .result_id_o
  );

  rrts_checker u_checker (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i       (busy_o),
    .action_i,
    .task_id_i,
    .new_state_i,
    .valid_i      (valid_o),
    .ok_i         (ok_o),
    .result_id_i  (result_id_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Returns at the edge that accepted the transaction.
  task automatic issue(logic [1:0] act, logic [15:0] tid, logic [1:0] st);
    int gap;
    if (burst_left == 0) begin
      no_gap     = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(10, 40);
    end
    burst_left--;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    action_i    <= act;
    task_id_i   <= tid;
    new_state_i <= st;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [1:0]  act;
    logic [15:0] tid;
    logic [1:0]  st;
    int          r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, bad ids and states, demotion, nothing ready, full table.
    issue(ACT_SELECT, 16'd0, ST_EMPTY);
    issue(ACT_SET, 16'd0, ST_READY);
    issue(ACT_NONE, 16'hFFFF, ST_BLOCKED);
    issue(ACT_CREATE, 16'hFFFF, ST_RUNNING);
    issue(ACT_CREATE, 16'd0, ST_EMPTY);
    issue(ACT_SELECT, 16'd0, ST_EMPTY);
    issue(ACT_SELECT, 16'd0, ST_EMPTY);
    issue(ACT_SET, 16'd1, ST_READY);
    issue(ACT_SET, 16'd1, ST_EMPTY);
    issue(ACT_SET, 16'd0, ST_RUNNING);
    issue(ACT_SET, 16'd0, ST_BLOCKED);
    issue(ACT_SET, 16'd1, ST_BLOCKED);
    issue(ACT_SELECT, 16'd0, ST_EMPTY);
    issue(ACT_SET, 16'hFFFF, ST_READY);
    issue(ACT_SET, 16'd1, ST_READY);
    issue(ACT_SELECT, 16'd0, ST_EMPTY);
    for (int i = 0; i < 15; i++) issue(ACT_CREATE, 16'd0, ST_EMPTY);
    issue(ACT_SET, 16'd15, ST_BLOCKED);
    issue(ACT_SELECT, 16'd0, ST_EMPTY);

    for (int i = 0; i < RandomCmds; i++) begin
      if (i == RandomCmds / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 12)      act = ACT_CREATE;
      else if (r < 50) act = ACT_SET;
      else if (r < 92) act = ACT_SELECT;
      else             act = ACT_NONE;
      // mostly ids that live in the table, sometimes anything
      tid = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 17)) : 16'($urandom);
      if ($urandom_range(0, 9) < 8)
        st = $urandom_range(0, 1) ? ST_READY : ST_BLOCKED;
      else
        st = 2'($urandom);
      issue(act, tid, st);
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> round_robin_task_scheduler_unit.f
+incdir+rtl/core
rtl/core/rrts_pkg.sv
rtl/core/rrts_cell.sv
rtl/core/round_robin_task_scheduler_unit.sv
dv/rrts_checker.sv
dv/testbench.sv
